// ===== rtl/bavg2_pkg.sv =====
// Shared constants and types for the 2x2 block-average downsampler.
`timescale 1ns / 1ps

package bavg2_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int CFG_W = 10;
    localparam int PIX_W = 8;
    localparam int SUM_W = 9;
    localparam int BLK_W = 8;

    localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;
    localparam logic [CFG_W-1:0] SIZE_MIN   = 10'd2;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // What the scan logic decides for one accepted pixel.
    typedef struct packed {
        logic             store;
        logic             emit;
        logic [BLK_W-1:0] block_col;
        logic [BLK_W-1:0] block_row;
        logic             frame_end;
    } scan_op_t;

endpackage

// ===== rtl/bavg2_line_store.sv =====
// Line store of horizontal pair sums: one write port, one registered read port.
`timescale 1ns / 1ps

module bavg2_line_store #(
    parameter int DEPTH = bavg2_pkg::DEF_MAX_WIDTH / 2,
    parameter int AW    = 8
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [bavg2_pkg::SUM_W-1:0] wr_value,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [bavg2_pkg::SUM_W-1:0] rd_value
);

    logic [bavg2_pkg::SUM_W-1:0] mem [DEPTH];
    logic [bavg2_pkg::SUM_W-1:0] rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_value_reg <= mem[rd_addr];
        end
    end

    assign rd_value = rd_value_reg;

endmodule

// ===== rtl/bavg2_scan.sv =====
// Size registers, raster counters and held pixel; decides each pixel's line store access.
`timescale 1ns / 1ps

module bavg2_scan #(
    parameter int MAX_WIDTH  = bavg2_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bavg2_pkg::DEF_MAX_HEIGHT,
    parameter int AW         = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [bavg2_pkg::CFG_W-1:0] wr_data,
    input  logic                        accept,
    input  logic [bavg2_pkg::PIX_W-1:0] pixel,
    output bavg2_pkg::scan_op_t         op,
    output logic [AW-1:0]               slot,
    output logic [bavg2_pkg::SUM_W-1:0] pair_sum
);

    localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = (WW > bavg2_pkg::CFG_W) ?
                          ((WW > HW) ? WW : HW) :
                          ((bavg2_pkg::CFG_W > HW) ? bavg2_pkg::CFG_W : HW);
    localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
    localparam logic [CMPW-1:0] MAXH_C = CMPW'(MAX_HEIGHT);
    localparam logic [CMPW-1:0] MIN_C  = CMPW'(bavg2_pkg::SIZE_MIN);

    logic [bavg2_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [bavg2_pkg::PIX_W-1:0] held_reg, held_next;
    logic [CW-1:0]               col_reg, col_next;
    logic [RW-1:0]               row_reg, row_next;

    logic [CMPW-1:0] width_ext, height_ext;
    logic [WW-1:0]   w_eff, w_even, col_ext, col_inc, w_last_blk;
    logic [HW-1:0]   h_eff, h_even, row_ext, row_inc, h_last_blk;
    logic [CW-1:0]   col_half;
    logic [RW-1:0]   row_half;
    logic            in_pairs;

    // Sizes outside the supported range are clamped.
    always_comb
    begin
        width_ext  = CMPW'(width_reg);
        height_ext = CMPW'(height_reg);
        priority if (width_ext < MIN_C)
            w_eff = WW'(MIN_C);
        else if (width_ext > MAXW_C)
            w_eff = WW'(MAXW_C);
        else
            w_eff = WW'(width_ext);
        priority if (height_ext < MIN_C)
            h_eff = HW'(MIN_C);
        else if (height_ext > MAXH_C)
            h_eff = HW'(MAXH_C);
        else
            h_eff = HW'(height_ext);
    end

    always_comb
    begin
        w_even     = {w_eff[WW-1:1], 1'b0};
        h_even     = {h_eff[HW-1:1], 1'b0};
        w_last_blk = (w_eff >> 1) - WW'(1);
        h_last_blk = (h_eff >> 1) - HW'(1);
        col_ext    = WW'(col_reg);
        row_ext    = HW'(row_reg);
        col_inc    = col_ext + WW'(1);
        row_inc    = row_ext + HW'(1);
        col_half   = col_reg >> 1;
        row_half   = row_reg >> 1;
        in_pairs   = (col_ext < w_even) && (row_ext < h_even);

        op.store     = in_pairs && col_reg[0] && !row_reg[0];
        op.emit      = in_pairs && col_reg[0] && row_reg[0];
        op.block_col = bavg2_pkg::BLK_W'(col_half);
        op.block_row = bavg2_pkg::BLK_W'(row_half);
        op.frame_end = (WW'(col_half) == w_last_blk) && (HW'(row_half) == h_last_blk);

        slot     = AW'(col_half);
        pair_sum = bavg2_pkg::SUM_W'(held_reg) + bavg2_pkg::SUM_W'(pixel);
    end

    always_comb
    begin
        held_next = held_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept)
        begin
            if (in_pairs && !col_reg[0])
            begin
                held_next = pixel;
            end
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                if (row_inc >= h_eff)
                    row_next = '0;
                else
                    row_next = RW'(row_inc);
            end
            else
            begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bavg2_pkg::SIZE_RESET;
            height_reg <= bavg2_pkg::SIZE_RESET;
            held_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            held_reg <= held_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            if (wr_en)
            begin
                unique case (bavg2_pkg::reg_index_t'(wr_index))
                    bavg2_pkg::REG_IMAGE_WIDTH:  width_reg  <= wr_data;
                    bavg2_pkg::REG_IMAGE_HEIGHT: height_reg <= wr_data;
                    default:                     width_reg  <= width_reg;
                endcase
            end
        end
    end

endmodule

// ===== rtl/block_average_downsample_2x2.sv =====
// Top level of the 2x2 block-average downsampler.
`timescale 1ns / 1ps

// Usage:
// Pixels enter in raster order on the pixel channel (pixel_valid / pixel_ready),
// one beat per pixel. Each pair of an even row leaves its sum in the line store;
// the second pixel of each pair in an odd row produces one beat on the block
// channel (block_valid / block_ready) with the floor mean of the 2x2 block, its
// column and row, and frame_end on the last full block of the frame. Odd
// trailing rows and columns are consumed and produce nothing.
// Sizes are written on wr_en / wr_index / wr_data while the block is idle.
// Throughput is one pixel per cycle unless the receiver stalls. A result beat
// leaves through the line store read stage and then the output register.
// When the receiver stalls, one result waits in the read stage and one in the
// output register; pixels are still taken until both are occupied.
// Reset clears the counters and the held pixel and sets both sizes to 512;
// the line store is not cleared and needs no time after reset.
module block_average_downsample_2x2 #(
    parameter int MAX_WIDTH  = bavg2_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bavg2_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [bavg2_pkg::CFG_W-1:0] wr_data,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  logic [bavg2_pkg::PIX_W-1:0] pixel,
    output logic                        block_valid,
    input  logic                        block_ready,
    output logic [bavg2_pkg::BLK_W-1:0] block_value,
    output logic [bavg2_pkg::BLK_W-1:0] block_col,
    output logic [bavg2_pkg::BLK_W-1:0] block_row,
    output logic                        frame_end
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bavg2_pkg::scan_op_t         op;
    logic [AW-1:0]               slot;
    logic [bavg2_pkg::SUM_W-1:0] pair_sum;
    logic [bavg2_pkg::SUM_W-1:0] line_sum;
    logic                        accept;
    logic                        s1_advance;

    logic                        s1_valid_reg, s1_valid_next;
    bavg2_pkg::scan_op_t         s1_op_reg;
    logic [bavg2_pkg::SUM_W-1:0] s1_pair_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [bavg2_pkg::BLK_W-1:0] out_value_reg, out_col_reg, out_row_reg;
    logic                        out_end_reg;
    logic [bavg2_pkg::SUM_W:0]   block_sum;

    bavg2_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .accept   (accept),
        .pixel    (pixel),
        .op       (op),
        .slot     (slot),
        .pair_sum (pair_sum)
    );

    // The read is issued only with an accepted beat, so a stalled read stage
    // keeps its line store data.
    bavg2_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_store (
        .clk      (clk),
        .wr_en    (accept && op.store),
        .wr_addr  (slot),
        .wr_value (pair_sum),
        .rd_en    (accept && op.emit),
        .rd_addr  (slot),
        .rd_value (line_sum)
    );

    always_comb
    begin
        s1_advance     = s1_valid_reg && (!out_valid_reg || block_ready);
        pixel_ready    = !s1_valid_reg || s1_advance;
        accept         = pixel_valid && pixel_ready;
        s1_valid_next  = (accept && op.emit) || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && !block_ready);
        block_sum      = (bavg2_pkg::SUM_W + 1)'(line_sum)
                       + (bavg2_pkg::SUM_W + 1)'(s1_pair_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && op.emit)
        begin
            s1_op_reg   <= op;
            s1_pair_reg <= pair_sum;
        end
        if (s1_advance)
        begin
            out_value_reg <= block_sum[bavg2_pkg::SUM_W:2];
            out_col_reg   <= s1_op_reg.block_col;
            out_row_reg   <= s1_op_reg.block_row;
            out_end_reg   <= s1_op_reg.frame_end;
        end
    end

    assign block_valid = out_valid_reg;
    assign block_value = out_value_reg;
    assign block_col   = out_col_reg;
    assign block_row   = out_row_reg;
    assign frame_end   = out_end_reg;

endmodule
